### hdl/hcw_pkg.sv
// shared types, constants and helper functions for the colour wheel pixel generator
`default_nettype none

package hcw_pkg;

	localparam logic [31:0] GREY_OUTSIDE = 32'hFF10_1010;
	localparam logic [7:0]  ALPHA_FULL   = 8'hFF;
	localparam logic [7:0]  VAL_BASE     = 8'd200;

	// configuration register indexes
	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_FRAME_TICK   = 2'd2;
	localparam logic [1:0] CFG_LINE_STRIDE  = 2'd3;

	// hue sector, each 43 hue steps wide but for the last, which is 41 wide
	typedef enum logic [2:0] {
		SEC_R_TO_Y,
		SEC_Y_TO_G,
		SEC_G_TO_C,
		SEC_C_TO_B,
		SEC_B_TO_M,
		SEC_M_TO_R
	} sector_t;

	// payload of one divider stage: partial remainders and quotients for sat and val
	typedef struct packed {
		logic [17:0] rs;
		logic [7:0]  qs;
		logic [15:0] rv;
		logic [5:0]  qv;
		logic [7:0]  hue;
		logic        in_wheel;
		logic [21:0] addr;
	} div_stage_t;

	// h / 43 for an 8-bit hue
	function automatic sector_t hue_sector(logic [7:0] h);
		sector_t s;
		if (h >= 8'd215) begin
			s = SEC_M_TO_R;
		end else if (h >= 8'd172) begin
			s = SEC_B_TO_M;
		end else if (h >= 8'd129) begin
			s = SEC_C_TO_B;
		end else if (h >= 8'd86) begin
			s = SEC_G_TO_C;
		end else if (h >= 8'd43) begin
			s = SEC_Y_TO_G;
		end else begin
			s = SEC_R_TO_Y;
		end
		return s;
	endfunction

	// first hue of a sector
	function automatic logic [7:0] sector_base(sector_t s);
		logic [7:0] b;
		unique case (s)
			SEC_R_TO_Y: b = 8'd0;
			SEC_Y_TO_G: b = 8'd43;
			SEC_G_TO_C: b = 8'd86;
			SEC_C_TO_B: b = 8'd129;
			SEC_B_TO_M: b = 8'd172;
			SEC_M_TO_R: b = 8'd215;
			default:    b = 8'd0;
		endcase
		return b;
	endfunction

	// exact x / 255 for x up to 255*255
	function automatic logic [7:0] div255(logic [15:0] x);
		logic [15:0] t;
		t = x + {8'd0, x[15:8]} + 16'd1;
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

### hdl/hsv_color_wheel_pixel_generator.sv
// colour wheel pixel generator: coordinate in, argb colour and buffer word address out
// throughput: one pixel per cycle while pixel_stall is low; the radius divisions run
//   as a 4-stage radix-4 long divider, one pair of quotient bits per stage, so no
//   unit is shared
// each stage loads when empty or when the stage after it moves, so bubbles close up
// reset clears all stage valid bits; frame registers reset to 320, 240, 0 and 320
`default_nettype none

module hsv_color_wheel_pixel_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        coord_valid,
	output logic             coord_stall,
	input  wire logic [9:0]  pixel_x,
	input  wire logic [9:0]  pixel_y,
	output logic             pixel_valid,
	input  wire logic        pixel_stall,
	output logic [31:0]      argb_colour,
	output logic [21:0]      word_address
);

	logic [10:0] frame_width_q;
	logic [10:0] frame_height_q;
	logic [5:0]  frame_tick_q;
	logic [12:0] line_stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 11'd320;
			frame_height_q <= 11'd240;
			frame_tick_q   <= 6'd0;
			line_stride_q  <= 13'd320;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hcw_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[10:0];
				hcw_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[10:0];
				hcw_pkg::CFG_FRAME_TICK:   frame_tick_q   <= cfg_data[5:0];
				hcw_pkg::CFG_LINE_STRIDE:  line_stride_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame geometry; the user must keep it stable while pixels are in flight, the block does not enforce it
	logic [9:0]  cx, cy, rad_lim, div;
	logic [10:0] min_dim;

	always_comb begin
		cx      = frame_width_q[10:1];
		cy      = frame_height_q[10:1];
		min_dim = (frame_width_q < frame_height_q) ? frame_width_q : frame_height_q;
		rad_lim = min_dim[10:1];
		div     = (rad_lim == 10'd0) ? 10'd1 : rad_lim;
	end

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8, ld9;

	always_comb begin
		ld9 = !v_s9 || !pixel_stall;
		ld8 = !v_s8 || ld9;
		ld7 = !v_s7 || ld8;
		ld6 = !v_s6 || ld7;
		ld5 = !v_s5 || ld6;
		ld4 = !v_s4 || ld5;
		ld3 = !v_s3 || ld4;
		ld2 = !v_s2 || ld3;
		ld1 = !v_s1 || ld2;
	end

	assign coord_stall = !ld1;
	assign pixel_valid = v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= coord_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
			if (ld6) v_s6 <= v_s5;
			if (ld7) v_s7 <= v_s6;
			if (ld8) v_s8 <= v_s7;
			if (ld9) v_s9 <= v_s8;
		end
	end

	// stage 1: distances from centre, hue, address
	logic [9:0]  adx, ady;
	logic [7:0]  hue_d, hue_c;
	logic [21:0] addr_prod;
	logic [21:0] addr_c;

	always_comb begin
		adx       = (pixel_x >= cx) ? pixel_x - cx : cx - pixel_x;
		ady       = (pixel_y >= cy) ? pixel_y - cy : cy - pixel_y;
		// 6*(x-cx) - 6*(y-cy) only matters mod 256
		hue_d     = pixel_x[7:0] - pixel_y[7:0] + cy[7:0] - cx[7:0];
		hue_c     = {hue_d[5:0], 2'b00} + {hue_d[6:0], 1'b0} + {frame_tick_q, 2'b00};
		addr_prod = {12'd0, pixel_y} * {9'd0, line_stride_q};
		addr_c    = addr_prod + {12'd0, pixel_x};
	end

	logic [9:0]  adx_s1, ady_s1;
	logic [7:0]  hue_s1;
	logic [21:0] addr_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			adx_s1  <= adx;
			ady_s1  <= ady;
			hue_s1  <= hue_c;
			addr_s1 <= addr_c;
		end
	end

	// stage 2: radius and the two dividends
	logic [9:0]      radius;
	hcw_pkg::div_stage_t dv_c2;

	always_comb begin
		radius         = (adx_s1 > ady_s1) ? adx_s1 : ady_s1;
		dv_c2.rs       = {radius, 8'd0} - {8'd0, radius};
		dv_c2.rv       = {radius, 6'd0} - {3'd0, radius, 3'd0} - {6'd0, radius};
		dv_c2.qs       = 8'd0;
		dv_c2.qv       = 6'd0;
		dv_c2.hue      = hue_s1;
		dv_c2.in_wheel = (radius <= rad_lim);
		dv_c2.addr     = addr_s1;
	end

	// two quotient bits of both divisions, highest bit hi
	function automatic hcw_pkg::div_stage_t div_step(hcw_pkg::div_stage_t st,
			logic [9:0] d, logic [2:0] hi);
		hcw_pkg::div_stage_t o;
		logic [2:0]  b;
		logic [17:0] ds;
		logic [15:0] dvv;
		o = st;
		for (int k = 0; k < 2; k++) begin
			b  = hi - 3'(k);
			ds = {8'd0, d} << b;
			if (o.rs >= ds) begin
				o.rs    = o.rs - ds;
				o.qs[b] = 1'b1;
			end
			// for a wheel pixel the val quotient never exceeds 55
			if (b <= 3'd5) begin
				dvv = {6'd0, d} << b;
				if (o.rv >= dvv) begin
					o.rv    = o.rv - dvv;
					o.qv[b] = 1'b1;
				end
			end
		end
		return o;
	endfunction

	hcw_pkg::div_stage_t dv_s2, dv_s3, dv_s4, dv_s5, dv_s6;

	always_ff @(posedge clk) begin
		if (ld2) dv_s2 <= dv_c2;
		if (ld3) dv_s3 <= div_step(dv_s2, div, 3'd7);
		if (ld4) dv_s4 <= div_step(dv_s3, div, 3'd5);
		if (ld5) dv_s5 <= div_step(dv_s4, div, 3'd3);
		if (ld6) dv_s6 <= div_step(dv_s5, div, 3'd1);
	end

	// stage 7: sat, val, sector and the first products
	logic [7:0]       sat, val, rem_base, rem;
	hcw_pkg::sector_t sec;

	always_comb begin
		sat      = 8'd255 - dv_s6.qs;
		val      = hcw_pkg::VAL_BASE + {2'd0, dv_s6.qv};
		sec      = hcw_pkg::hue_sector(dv_s6.hue);
		rem_base = dv_s6.hue - hcw_pkg::sector_base(sec);
		rem      = {rem_base[5:0], 2'b00} + {rem_base[6:0], 1'b0};
	end

	logic [7:0]       val_s7;
	hcw_pkg::sector_t sec_s7;
	logic [15:0]      pm_s7, sr_s7, st_s7;
	logic             in_wheel_s7;
	logic [21:0]      addr_s7;

	always_ff @(posedge clk) begin
		if (ld7) begin
			val_s7      <= val;
			sec_s7      <= sec;
			// 255 - sat is the sat quotient itself
			pm_s7       <= {8'd0, val} * {8'd0, dv_s6.qs};
			sr_s7       <= {8'd0, sat} * {8'd0, rem};
			st_s7       <= {8'd0, sat} * {8'd0, 8'd255 - rem};
			in_wheel_s7 <= dv_s6.in_wheel;
			addr_s7     <= dv_s6.addr;
		end
	end

	// stage 8: p, and the products for q and t
	logic [7:0] a_c, b_c;

	always_comb begin
		a_c = hcw_pkg::div255(sr_s7);
		b_c = hcw_pkg::div255(st_s7);
	end

	logic [7:0]       p_s8, val_s8;
	logic [15:0]      qm_s8, tm_s8;
	hcw_pkg::sector_t sec_s8;
	logic             in_wheel_s8;
	logic [21:0]      addr_s8;

	always_ff @(posedge clk) begin
		if (ld8) begin
			p_s8        <= hcw_pkg::div255(pm_s7);
			qm_s8       <= {8'd0, val_s7} * {8'd0, 8'd255 - a_c};
			tm_s8       <= {8'd0, val_s7} * {8'd0, 8'd255 - b_c};
			val_s8      <= val_s7;
			sec_s8      <= sec_s7;
			in_wheel_s8 <= in_wheel_s7;
			addr_s8     <= addr_s7;
		end
	end

	// stage 9: q, t and the channel selection
	logic [7:0]  q_c, t_c, r_c, g_c, b_ch;
	logic [31:0] colour_c;

	always_comb begin
		q_c = hcw_pkg::div255(qm_s8);
		t_c = hcw_pkg::div255(tm_s8);
		unique case (sec_s8)
			hcw_pkg::SEC_R_TO_Y: begin r_c = val_s8; g_c = t_c;    b_ch = p_s8;   end
			hcw_pkg::SEC_Y_TO_G: begin r_c = q_c;    g_c = val_s8; b_ch = p_s8;   end
			hcw_pkg::SEC_G_TO_C: begin r_c = p_s8;   g_c = val_s8; b_ch = t_c;    end
			hcw_pkg::SEC_C_TO_B: begin r_c = p_s8;   g_c = q_c;    b_ch = val_s8; end
			hcw_pkg::SEC_B_TO_M: begin r_c = t_c;    g_c = p_s8;   b_ch = val_s8; end
			default:             begin r_c = val_s8; g_c = p_s8;   b_ch = q_c;    end
		endcase
		colour_c = in_wheel_s8 ? {hcw_pkg::ALPHA_FULL, r_c, g_c, b_ch}
			: hcw_pkg::GREY_OUTSIDE;
	end

	logic [31:0] colour_s9;
	logic [21:0] addr_s9;

	always_ff @(posedge clk) begin
		if (ld9) begin
			colour_s9 <= colour_c;
			addr_s9   <= addr_s8;
		end
	end

	assign argb_colour  = colour_s9;
	assign word_address = addr_s9;

	// input backs up only when every stage is full and the output is held
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		coord_stall |-> (pixel_valid && pixel_stall && v_s1 && v_s8))
		else $error("input stalled with room in the pipeline");

	// a wheel pixel leaves the divider with a remainder below the divisor
	a_div_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && dv_s6.in_wheel) |-> (dv_s6.rs < {8'd0, div}))
		else $error("sat division remainder not reduced");

	a_div_val_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && dv_s6.in_wheel) |-> (dv_s6.rv < {6'd0, div} && dv_s6.qv <= 6'd55))
		else $error("val division out of range");

	// a held pixel beat keeps its colour
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_stall) |=> (pixel_valid && $stable(argb_colour)))
		else $error("held pixel changed");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> (argb_colour[31:24] == hcw_pkg::ALPHA_FULL))
		else $error("alpha byte not opaque");

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the colour wheel pixel generator
module tb_top;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_SETS  = 9;
	localparam int SET_ITEMS    = 148;
	localparam int SQUEEZE_BEAT = 720;

	typedef struct packed {
		logic [31:0] argb;
		logic [21:0] addr;
	} pixel_t;

	class wheel_scoreboard_t;
		logic [10:0] width;
		logic [10:0] height;
		logic [5:0]  tick;
		logic [12:0] stride;
		pixel_t      expected_pixels[$];
		int          errors;
		int          checked;

		function new();
			width = 11'd320;
			height = 11'd240;
			tick = 6'd0;
			stride = 13'd320;
			errors = 0;
			checked = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [12:0] val);
			case (idx)
				hcw_pkg::CFG_FRAME_WIDTH:  width = val[10:0];
				hcw_pkg::CFG_FRAME_HEIGHT: height = val[10:0];
				hcw_pkg::CFG_FRAME_TICK:   tick = val[5:0];
				hcw_pkg::CFG_LINE_STRIDE:  stride = val;
				default: ;
			endcase
		endfunction

		function pixel_t wheel_pixel(logic [9:0] x, logic [9:0] y);
			logic [31:0] cx, cy, lim, div, adx, ady, rad;
			logic [31:0] hue, scaled, sat, val, region, rem, p, q, t, r, g, b;
			hcw_pkg::sector_t sec;
			pixel_t res;
			cx = width / 2;
			cy = height / 2;
			lim = ((width < height) ? width : height) / 2;
			div = (lim == 0) ? 32'd1 : lim;
			adx = (x >= cx) ? x - cx : cx - x;
			ady = (y >= cy) ? y - cy : cy - y;
			rad = (adx > ady) ? adx : ady;
			if (rad > lim) begin
				res.argb = hcw_pkg::GREY_OUTSIDE;
			end else begin
				// differences wrap, only the low byte matters
				hue = (32'd6 * (x - cx) - 32'd6 * (y - cy) + 32'd4 * tick) & 32'hFF;
				scaled = (rad * 32'd255) / div;
				sat = (scaled > 32'd255) ? 32'd0 : 32'd255 - scaled;
				val = (32'd200 + (rad * 32'd55) / div) & 32'hFF;
				region = hue / 32'd43;
				rem = ((hue - region * 32'd43) * 32'd6) & 32'hFF;
				p = (val * (32'd255 - sat)) / 32'd255;
				q = (val * (32'd255 - (sat * rem) / 32'd255)) / 32'd255;
				t = (val * (32'd255 - (sat * (32'd255 - rem)) / 32'd255)) / 32'd255;
				sec = hcw_pkg::sector_t'(region[2:0]);
				case (sec)
					hcw_pkg::SEC_R_TO_Y: begin r = val; g = t; b = p; end
					hcw_pkg::SEC_Y_TO_G: begin r = q; g = val; b = p; end
					hcw_pkg::SEC_G_TO_C: begin r = p; g = val; b = t; end
					hcw_pkg::SEC_C_TO_B: begin r = p; g = q; b = val; end
					hcw_pkg::SEC_B_TO_M: begin r = t; g = p; b = val; end
					default:             begin r = val; g = p; b = q; end
				endcase
				res.argb = {hcw_pkg::ALPHA_FULL, r[7:0], g[7:0], b[7:0]};
			end
			res.addr = {12'd0, y} * {9'd0, stride} + {12'd0, x};
			return res;
		endfunction

		function void note_coord(logic [9:0] x, logic [9:0] y);
			expected_pixels.push_back(wheel_pixel(x, y));
		endfunction

		function void check_pixel(logic [31:0] argb, logic [21:0] addr);
			pixel_t exp_px;
			if (expected_pixels.size() == 0) begin
				$error("pixel beat with nothing expected: argb_colour %h word_address %h",
					argb, addr);
				errors++;
				return;
			end
			exp_px = expected_pixels.pop_front();
			checked++;
			if (argb !== exp_px.argb) begin
				$error("argb_colour expected %h actual %h", exp_px.argb, argb);
				errors++;
			end
			if (addr !== exp_px.addr) begin
				$error("word_address expected %h actual %h", exp_px.addr, addr);
				errors++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = hcw_pkg::CFG_FRAME_WIDTH;
	logic [12:0] cfg_data = '0;
	logic        coord_valid = 1'b0;
	logic        coord_stall;
	logic [9:0]  pixel_x = '0;
	logic [9:0]  pixel_y = '0;
	logic        pixel_valid;
	logic        pixel_stall = 1'b0;
	logic [31:0] argb_colour;
	logic [21:0] word_address;

	wheel_scoreboard_t sb = new();
	int sent_coords = 0;
	int frame_sets = 1;
	int idle_cycles = 0;

	hsv_color_wheel_pixel_generator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.coord_valid  (coord_valid),
		.coord_stall  (coord_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.argb_colour  (argb_colour),
		.word_address (word_address)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((coord_valid && coord_stall === 1'b0) || (pixel_valid === 1'b1 && !pixel_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_coord(logic [9:0] x, logic [9:0] y);
		int gap;
		// every fourth stretch of 50 beats runs back to back
		gap = ((sent_coords / 50) % 4 == 1) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			coord_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coord_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (coord_stall !== 1'b0) @(posedge clk);
		sb.note_coord(x, y);
		sent_coords++;
	endtask

	task automatic drain();
		coord_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_frame(int w, int h, int tk, int stride);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= hcw_pkg::CFG_FRAME_WIDTH;
		cfg_data <= 13'(w);
		@(posedge clk);
		sb.set_register(hcw_pkg::CFG_FRAME_WIDTH, 13'(w));
		cfg_index <= hcw_pkg::CFG_FRAME_HEIGHT;
		cfg_data <= 13'(h);
		@(posedge clk);
		sb.set_register(hcw_pkg::CFG_FRAME_HEIGHT, 13'(h));
		cfg_index <= hcw_pkg::CFG_FRAME_TICK;
		cfg_data <= 13'(tk);
		@(posedge clk);
		sb.set_register(hcw_pkg::CFG_FRAME_TICK, 13'(tk));
		cfg_index <= hcw_pkg::CFG_LINE_STRIDE;
		cfg_data <= 13'(stride);
		@(posedge clk);
		sb.set_register(hcw_pkg::CFG_LINE_STRIDE, 13'(stride));
		cfg_we <= 1'b0;
		frame_sets++;
	endtask

	// receiving side
	initial begin
		int hold;
		int beats;
		beats = 0;
		forever begin
			hold = ((beats / 60) % 5 == 2) ? 0 : $urandom_range(0, 4);
			// one long hold-off so the pipeline backs up into the input
			if (beats == SQUEEZE_BEAT) hold = 80;
			if (hold > 0) begin
				pixel_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				pixel_stall <= 1'b0;
			end
			@(posedge clk);
			while (pixel_valid !== 1'b1) @(posedge clk);
			sb.check_pixel(argb_colour, word_address);
			beats++;
		end
	end

	initial begin
		int w, h, tk, stride, sel;
		int xmax, ymax;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame 320x240: centre, corners, wheel rim and beyond, off-frame points
		send_coord(10'd0, 10'd0);
		send_coord(10'd1023, 10'd1023);
		send_coord(10'd160, 10'd120);
		send_coord(10'd280, 10'd120);
		send_coord(10'd281, 10'd120);
		send_coord(10'd160, 10'd0);
		send_coord(10'd160, 10'd240);
		send_coord(10'd40, 10'd120);
		send_coord(10'd319, 10'd239);
		send_coord(10'd320, 10'd240);
		send_coord(10'd1023, 10'd0);
		send_coord(10'd0, 10'd1023);
		send_coord(10'd200, 10'd100);
		send_coord(10'd130, 10'd150);

		// one-pixel frame: radius limit of zero, stride of zero
		load_frame(1, 1, 63, 0);
		send_coord(10'd0, 10'd0);
		send_coord(10'd1, 10'd0);
		send_coord(10'd0, 10'd1);
		send_coord(10'd1023, 10'd1023);
		send_coord(10'd512, 10'd0);

		// largest frame with a stride wide enough to wrap the address
		load_frame(1024, 1024, 32, 8191);
		send_coord(10'd1023, 10'd1023);
		send_coord(10'd512, 10'd512);
		send_coord(10'd0, 10'd0);
		send_coord(10'd1023, 10'd0);
		send_coord(10'd0, 10'd1023);

		for (int s = 0; s < RANDOM_SETS; s++) begin
			case (s)
				0: begin w = 1024; h = 1024; tk = 0; stride = 4096; end
				1: begin w = 1; h = 1024; tk = 63; stride = 1; end
				2: begin w = 1024; h = 1; tk = $urandom_range(0, 63); stride = 4096; end
				3: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16);
					tk = $urandom_range(0, 63); stride = $urandom_range(1, 64); end
				default: begin w = $urandom_range(1, 1024); h = $urandom_range(1, 1024);
					tk = $urandom_range(0, 63); stride = $urandom_range(1, 4096); end
			endcase
			load_frame(w, h, tk, stride);
			xmax = (w > 1024) ? 1023 : w - 1;
			ymax = (h > 1024) ? 1023 : h - 1;
			for (int i = 0; i < SET_ITEMS; i++) begin
				sel = $urandom_range(0, 9);
				// mostly in-frame points, now and then anywhere in the coordinate space
				if (sel < 8)
					send_coord(10'($urandom_range(0, xmax)), 10'($urandom_range(0, ymax)));
				else
					send_coord(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
			end
		end

		drain();
		if (sb.pending() != 0) begin
			$error("%0d pixel beats never arrived", sb.pending());
			sb.errors++;
		end
		$display("checked %0d pixel beats of %0d coordinate beats over %0d frame settings",
			sb.checked, sent_coords, frame_sets);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
